// ===== rtl/core/speed_command_frame_parser_top_macros.svh =====
// Assertion macros shared by the speed command frame parser RTL.
`ifndef SPEED_COMMAND_FRAME_PARSER_TOP_MACROS_SVH
`define SPEED_COMMAND_FRAME_PARSER_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define SCFP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scfp assertion failed");
// Next-cycle implication.
`define SCFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scfp assertion failed");
`else
`define SCFP_ASSERT_SAME(label, clk, rst, ante, cons)
`define SCFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/scfp_pkg.sv =====
// Constants and types of the speed command frame parser.
package scfp_pkg;

   localparam int WinLen   = 11;
   localparam int StoreLen = WinLen - 1;
   localparam int CountW   = $clog2(WinLen);

   localparam logic [7:0] HdrByte     = 8'hAA;
   localparam logic [7:0] TailByte    = 8'h55;
   localparam logic [7:0] FrameLen    = 8'(WinLen);
   localparam logic [7:0] CmdGroupOne = 8'h01;
   localparam logic [7:0] CmdGroupTwo = 8'h02;

   // target_group codes
   localparam logic [1:0] GroupFirst  = 2'd0;
   localparam logic [1:0] GroupSecond = 2'd1;
   localparam logic [1:0] GroupOther  = 2'd2;

   typedef logic [StoreLen-1:0][7:0] store_type;
   typedef logic [WinLen-1:0][7:0]   window_type;
   typedef logic [CountW-1:0]        count_type;

   typedef struct packed {
      logic [1:0]         target_group;
      logic [7:0]         command_byte;
      logic signed [15:0] speed_first;
      logic signed [15:0] speed_second;
      logic signed [15:0] speed_third;
   } result_type;

   // Outcome of one byte on the window
   typedef struct packed {
      logic      emit;
      count_type count;
   } status_type;

endpackage

// ===== rtl/core/scfp_if.sv =====
// Valid/ready channel interfaces for received bytes and parsed frames.
interface scfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         target_group;
   logic [7:0]         command_byte;
   logic signed [15:0] speed_first;
   logic signed [15:0] speed_second;
   logic signed [15:0] speed_third;

   modport source (output valid, output target_group, output command_byte,
                   output speed_first, output speed_second, output speed_third,
                   input ready);
   modport sink (input valid, input target_group, input command_byte,
                 input speed_first, input speed_second, input speed_third,
                 output ready);
endinterface

// ===== rtl/core/scfp_frame_check.sv =====
// Window append, frame check and resync shift for one received byte.
module scfp_frame_check
   import scfp_pkg::*;
(
   input  store_type  win,
   input  count_type  count,
   input  logic [7:0] rx_byte,
   output store_type  win_next,
   output status_type status,
   output result_type result
);

   window_type      full;
   window_type      shifted;
   logic            is_full;
   logic [7:0]      len;
   logic [7:0]      parity;
   logic [3:0]      drop;
   logic            good;

   // Full window: stored bytes plus the incoming one at the end
   assign full    = {rx_byte, win};
   assign is_full = (count == count_type'(StoreLen));
   assign len     = full[1];
   assign parity  = full[1] ^ full[2] ^ full[3] ^ full[4] ^
                    full[5] ^ full[6] ^ full[7] ^ full[8];

   // How many bytes leave the front of a full window
   always_comb begin
      good = 1'b0;
      if (full[0] != HdrByte) begin
         drop = 4'd1;
      end else if (len > FrameLen) begin
         drop = 4'(WinLen);
      end else if (len != FrameLen) begin
         drop = (len == 8'd0) ? 4'd1 : len[3:0];
      end else begin
         drop = 4'(WinLen);
         good = (full[WinLen-1] == TailByte) && (parity == full[StoreLen-1]);
      end
   end

   assign shifted = full >> {drop, 3'b000};

   // Next window contents and fill count
   always_comb begin
      win_next = win;
      if (is_full) begin
         win_next     = shifted[StoreLen-1:0];
         status.count = count_type'(4'(WinLen) - drop);
         status.emit  = good;
      end else begin
         win_next[count] = rx_byte;
         status.count    = count + count_type'(1);
         status.emit     = 1'b0;
      end
   end

   // Result fields of a good frame
   always_comb begin
      result.command_byte = full[2];
      result.speed_first  = '0;
      result.speed_second = '0;
      result.speed_third  = '0;
      if (full[2] == CmdGroupOne || full[2] == CmdGroupTwo) begin
         result.target_group = (full[2] == CmdGroupOne) ? GroupFirst : GroupSecond;
         result.speed_first  = signed'({full[4], full[3]});
         result.speed_second = signed'({full[6], full[5]});
         result.speed_third  = signed'({full[8], full[7]});
      end else begin
         result.target_group = GroupOther;
      end
   end

endmodule

// ===== rtl/core/speed_command_frame_parser_top.sv =====
// Speed command frame parser: takes one received byte per transfer and
// collects 11-byte frames (0xAA header, length 11, command, three signed
// little-endian 16-bit speeds, XOR of bytes 1..8, 0x55 tail). A bad header,
// length, tail or checksum drops bytes from the front of the window to
// resynchronize; a good frame yields one result transfer. The block takes a
// byte every cycle while the result register is free or being read; a byte
// waits in the input register, where the window check and shift run in one
// pass, and a frame's result is then written to the result register, which
// holds it while the sink stalls; bytes then wait in the input register.
`include "speed_command_frame_parser_top_macros.svh"

module speed_command_frame_parser_top
   import scfp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   scfp_req_if.sink   req_if,
   scfp_rsp_if.source rsp_if
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   store_type  win_ff;
   store_type  win_in;
   count_type  count_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   status_type status;
   result_type result;
   logic       advance;

   // Byte in the input register moves on when the result register is free or being read
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   scfp_frame_check u_check (
      .win      (win_ff),
      .count    (count_ff),
      .rx_byte  (in_byte_ff),
      .win_next (win_in),
      .status   (status),
      .result   (result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_if.ready && req_if.valid) begin
         in_byte_ff <= req_if.rx_byte;
      end
   end

   // Window state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (advance) begin
         count_ff <= status.count;
      end
      if (advance) begin
         win_ff <= win_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= status.emit;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && status.emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.target_group = rsp_data_ff.target_group;
   assign rsp_if.command_byte = rsp_data_ff.command_byte;
   assign rsp_if.speed_first  = rsp_data_ff.speed_first;
   assign rsp_if.speed_second = rsp_data_ff.speed_second;
   assign rsp_if.speed_third  = rsp_data_ff.speed_third;

   // Fill count stays within the stored part of the window
   `SCFP_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= count_type'(StoreLen))
   // A frame is only reported from a full window
   `SCFP_ASSERT_SAME(a_emit_full, clock, reset, advance && status.emit, count_ff == count_type'(StoreLen))
   // A reported frame empties the window
   `SCFP_ASSERT_NEXT(a_emit_flush, clock, reset, advance && status.emit, count_ff == '0)

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the speed command frame parser top level.
module tb;
   import scfp_pkg::*;

   localparam int ResetCycles  = 12;
   localparam int HoldCycles   = 90;
   localparam int SettleCycles = 8;
   localparam int ByteTarget   = 900;
   localparam int TimeLimit    = 2_000_000;

   // Expected parsed frames, kept by running the incoming bytes through a
   // private copy of the window logic
   class speed_frame_tracker;
      logic [7:0]  window [WinLen];
      int unsigned fill;
      result_type  expected_frames[$];
      int unsigned mismatches;
      int unsigned frames_seen;
      int unsigned rejects;
      int unsigned group_hits[3];

      function new();
         fill        = 0;
         mismatches  = 0;
         frames_seen = 0;
         rejects     = 0;
         group_hits  = '{0, 0, 0};
      endfunction

      task report_mismatch(string what);
         if (mismatches < 40) $display("ERROR: %s", what);
         mismatches++;
      endtask

      function void drop_front(int unsigned n);
         int unsigned i;
         if (n >= fill) begin
            fill = 0;
         end else begin
            for (i = 0; i < fill - n; i++) window[i] = window[i + n];
            fill = fill - n;
         end
      endfunction

      // One accepted byte: append, then check a full window
      function void note_byte(logic [7:0] rx);
         logic [7:0] xsum;
         result_type frame;
         int         i;
         if (fill < WinLen) begin
            window[fill] = rx;
            fill++;
         end
         if (fill < WinLen) return;
         if (window[0] != HdrByte) begin
            rejects++;
            drop_front(1);
            return;
         end
         if (window[1] > FrameLen) begin
            rejects++;
            drop_front(WinLen);
            return;
         end
         if (window[1] != FrameLen) begin
            rejects++;
            // zero length still advances by one byte
            drop_front((window[1] == 8'd0) ? 1 : int'(window[1]));
            return;
         end
         if (window[WinLen-1] != TailByte) begin
            rejects++;
            drop_front(WinLen);
            return;
         end
         xsum = 8'd0;
         for (i = 1; i < WinLen - 2; i++) xsum ^= window[i];
         if (xsum != window[WinLen-2]) begin
            rejects++;
            drop_front(WinLen);
            return;
         end
         frame.command_byte = window[2];
         if (window[2] == CmdGroupOne || window[2] == CmdGroupTwo) begin
            frame.target_group = (window[2] == CmdGroupOne) ? GroupFirst : GroupSecond;
            frame.speed_first  = {window[4], window[3]};
            frame.speed_second = {window[6], window[5]};
            frame.speed_third  = {window[8], window[7]};
         end else begin
            frame.target_group = GroupOther;
            frame.speed_first  = '0;
            frame.speed_second = '0;
            frame.speed_third  = '0;
         end
         expected_frames.push_back(frame);
         drop_front(WinLen);
      endfunction

      // One accepted result against the oldest expected frame
      task check_frame(result_type got);
         result_type want;
         if (expected_frames.size() == 0) begin
            report_mismatch($sformatf("unexpected frame, command %02h", got.command_byte));
            return;
         end
         want = expected_frames.pop_front();
         frames_seen++;
         if (want.target_group <= GroupOther) group_hits[want.target_group]++;
         if (got.target_group !== want.target_group)
            report_mismatch($sformatf("target_group %0d, expected %0d",
                                      got.target_group, want.target_group));
         if (got.command_byte !== want.command_byte)
            report_mismatch($sformatf("command_byte %02h, expected %02h",
                                      got.command_byte, want.command_byte));
         if (got.speed_first !== want.speed_first)
            report_mismatch($sformatf("speed_first %0d, expected %0d",
                                      got.speed_first, want.speed_first));
         if (got.speed_second !== want.speed_second)
            report_mismatch($sformatf("speed_second %0d, expected %0d",
                                      got.speed_second, want.speed_second));
         if (got.speed_third !== want.speed_third)
            report_mismatch($sformatf("speed_third %0d, expected %0d",
                                      got.speed_third, want.speed_third));
      endtask
   endclass

   logic clock;
   logic reset;

   scfp_req_if req_bus();
   scfp_rsp_if rsp_bus();

   speed_frame_tracker tracker = new();

   int unsigned bytes_sent   = 0;
   int unsigned burst_left   = 0;
   bit          hold_request = 1'b0;

   speed_command_frame_parser_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      #(TimeLimit);
      $display("FAIL speed_command_frame_parser_top");
      $finish;
   end

   // Byte and result transfer monitors
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) tracker.note_byte(req_bus.rx_byte);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_frame(result_type'{rsp_bus.target_group, rsp_bus.command_byte,
                                          rsp_bus.speed_first, rsp_bus.speed_second,
                                          rsp_bus.speed_third});
   end

   // Result side: random stall spans, plus one long hold-off on request
   initial begin
      int mode;
      int span;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(4, 30);
            while (span > 0 && !hold_request) begin
               case (mode)
                  0: rsp_bus.ready <= 1'b1;
                  1: rsp_bus.ready <= 1'($urandom_range(0, 1));
                  default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
               span--;
            end
         end
      end
   end

   // Offer one byte, with bursts and gaps, and wait for its transfer
   task automatic send_byte(input logic [7:0] rx);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid   <= 1'b0;
            req_bus.rx_byte <= 8'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= rx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_bytes(input window_type frame, input int count);
      int i;
      for (i = 0; i < count; i++) send_byte(frame[i]);
   endtask

   // Stop offering until every expected frame has come out
   task automatic drain_frames();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_frames.size() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   function automatic window_type make_frame(logic [7:0] cmd, logic [15:0] s1,
                                             logic [15:0] s2, logic [15:0] s3);
      window_type frame;
      logic [7:0] xsum;
      int         i;
      frame[0] = HdrByte;
      frame[1] = FrameLen;
      frame[2] = cmd;
      frame[3] = s1[7:0];
      frame[4] = s1[15:8];
      frame[5] = s2[7:0];
      frame[6] = s2[15:8];
      frame[7] = s3[7:0];
      frame[8] = s3[15:8];
      xsum = 8'd0;
      for (i = 1; i < WinLen - 2; i++) xsum ^= frame[i];
      frame[WinLen-2] = xsum;
      frame[WinLen-1] = TailByte;
      return frame;
   endfunction

   function automatic logic [15:0] pick_speed();
      case ($urandom_range(0, 11))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_command();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return CmdGroupOne;
      if (roll < 80) return CmdGroupTwo;
      return 8'($urandom);
   endfunction

   // Stimulus
   initial begin
      window_type  frame;
      int          kind;
      int          frame_idx;
      int          i;
      logic [7:0]  noise;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // One good frame per command kind, speeds at their extremes in the first two
      send_bytes(make_frame(CmdGroupOne, 16'h8000, 16'h7FFF, 16'hFFFF), WinLen);
      send_bytes(make_frame(CmdGroupTwo, 16'h7FFF, 16'h0000, 16'h8000), WinLen);
      send_bytes(make_frame(8'hFF, 16'h1234, 16'h5678, 16'h9ABC), WinLen);
      // Resync chain: bad header, zero length, bad header, length above eleven
      send_byte(8'h00);
      send_byte(HdrByte);
      send_byte(8'h00);
      send_byte(HdrByte);
      send_byte(8'h0C);
      for (i = 0; i < 9; i++) send_byte(8'h11);
      drain_frames();

      // Random frames, mostly well formed, some damaged, plus line noise
      frame_idx = 0;
      while (bytes_sent < ByteTarget) begin
         if (frame_idx == 15) hold_request = 1'b1;
         if (frame_idx == 40) drain_frames();
         frame = make_frame(pick_command(), pick_speed(), pick_speed(), pick_speed());
         kind  = $urandom_range(0, 99);
         if (kind < 65) begin
            send_bytes(frame, WinLen);
         end else if (kind < 72) begin
            // broken checksum
            frame[WinLen-2] ^= 8'(1 << $urandom_range(0, 7));
            send_bytes(frame, WinLen);
         end else if (kind < 78) begin
            // broken tail
            frame[WinLen-1] ^= 8'($urandom_range(1, 255));
            send_bytes(frame, WinLen);
         end else if (kind < 85) begin
            // wrong length, often a short one
            frame[1] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 10))
                                                   : 8'($urandom);
            if (frame[1] == FrameLen) frame[1] = 8'h00;
            send_bytes(frame, WinLen);
         end else if (kind < 93) begin
            for (i = $urandom_range(1, 5); i > 0; i--) begin
               noise = ($urandom_range(0, 3) == 0) ? HdrByte : 8'($urandom);
               send_byte(noise);
            end
         end else begin
            // truncated frame
            send_bytes(frame, $urandom_range(1, WinLen - 1));
         end
         frame_idx++;
      end

      drain_frames();
      repeat (SettleCycles) @(posedge clock);
      if (tracker.expected_frames.size() != 0)
         tracker.report_mismatch($sformatf("%0d frames never came out",
                                           tracker.expected_frames.size()));
      $display("Run covered %0d bytes, %0d rejected windows, %0d frames checked",
               bytes_sent, tracker.rejects, tracker.frames_seen);
      $display("Frames by group: first %0d, second %0d, other %0d; mismatches %0d",
               tracker.group_hits[0], tracker.group_hits[1], tracker.group_hits[2],
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("PASS speed_command_frame_parser_top");
      end else begin
         $display("FAIL speed_command_frame_parser_top");
      end
      $finish;
   end

endmodule
